// File: design/telemetry_group_frame_receiver_top_defines.svh
// Assertion macros for the telemetry group frame receiver.
`ifndef TELEMETRY_GROUP_FRAME_RECEIVER_TOP_DEFINES_SVH
`define TELEMETRY_GROUP_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define TGFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define TGFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define TGFR_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/tgfr_pkg.sv
// Shared constants, types and helpers of the telemetry group frame receiver.
`default_nettype none
package tgfr_pkg;

   localparam int STATUS_GROUP_SIZE  = 16;
   localparam int MEASURE_GROUP_SIZE = 16;
   localparam int GROUP_COUNT        = 4;
   localparam int GROUP_W            = $clog2(GROUP_COUNT);

   localparam int STORE_DEPTH = 32;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int MEM_AW      = STORE_AW + 1;
   localparam int MEM_DEPTH   = 2 * STORE_DEPTH;

   localparam int BYTE_W      = 8;
   localparam int CMD_W       = 3;
   localparam int TIMER_W     = 24;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 1;

   localparam int QUEUE_DEPTH = 3;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] TYPE_STATUS1  = 8'h0C;
   localparam logic [BYTE_W-1:0] TYPE_STATUS2  = 8'h1C;
   localparam logic [BYTE_W-1:0] TYPE_MEAS1    = 8'h05;
   localparam logic [BYTE_W-1:0] TYPE_MEAS2    = 8'h15;
   localparam logic [BYTE_W-1:0] TYPE_POSITION = 8'h03;
   localparam logic [BYTE_W-1:0] HEADER_BYTES  = 8'h04;

   localparam logic [BYTE_W-1:0] STATUS_LIMIT  = BYTE_W'(STATUS_GROUP_SIZE) + HEADER_BYTES;
   localparam logic [BYTE_W-1:0] MEASURE_LIMIT = BYTE_W'(MEASURE_GROUP_SIZE) + HEADER_BYTES;

   localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);
   localparam logic               SECOND_RESET  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_BYTE  = 3'd0,
      CMD_TICK  = 3'd1,
      CMD_POLL  = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT = 1'b0,
      CSR_SECOND  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               hit;
      logic [GROUP_W-1:0] group;
   } group_sel_type;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
      logic              re;
      logic [MEM_AW-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic                   valid;
      logic                   frame_done;
      logic                   is_read;
      logic [GROUP_COUNT-1:0] invalid_flags;
      logic [GROUP_COUNT-1:0] timers_running;
   } stage_type;

   typedef struct packed {
      logic                   frame_done;
      logic [BYTE_W-1:0]      read_value;
      logic [GROUP_COUNT-1:0] invalid_flags;
      logic [GROUP_COUNT-1:0] timers_running;
   } result_type;

   // Group type byte to group number.
   function automatic group_sel_type group_of_type(input logic [BYTE_W-1:0] t);
      group_sel_type sel;
      sel = '0;
      case (t)
         TYPE_STATUS1: begin
            sel.hit = 1'b1; sel.group = 2'd0;
         end
         TYPE_STATUS2: begin
            sel.hit = 1'b1; sel.group = 2'd1;
         end
         TYPE_MEAS1: begin
            sel.hit = 1'b1; sel.group = 2'd2;
         end
         TYPE_MEAS2: begin
            sel.hit = 1'b1; sel.group = 2'd3;
         end
         default: begin
            sel = '0;
         end
      endcase
      return sel;
   endfunction

endpackage
`default_nettype wire

// File: design/tgfr_if.sv
// Item channel interfaces: command input and result output.
`default_nettype none
interface tgfr_req_if;
   import tgfr_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [BYTE_W-1:0]   rx_byte;
   logic [GROUP_W-1:0]  group_index;
   logic                read_table;
   logic [STORE_AW-1:0] read_index;
   modport source (output valid, cmd, rx_byte, group_index, read_table, read_index,
                   input ready);
   modport sink   (input valid, cmd, rx_byte, group_index, read_table, read_index,
                   output ready);
endinterface

interface tgfr_rsp_if;
   import tgfr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   frame_done;
   logic [BYTE_W-1:0]      read_value;
   logic [GROUP_COUNT-1:0] invalid_flags;
   logic [GROUP_COUNT-1:0] timers_running;
   modport source (output valid, frame_done, read_value, invalid_flags, timers_running,
                   input ready);
   modport sink   (input valid, frame_done, read_value, invalid_flags, timers_running,
                   output ready);
endinterface
`default_nettype wire

// File: design/tgfr_mem.sv
// Status and measurement store: one 64-byte memory, registered read, per-entry valid bits.
`default_nettype none
module tgfr_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  tgfr_pkg::mem_req_type     mem_req,
   output logic [tgfr_pkg::BYTE_W-1:0] rd_data
);
   import tgfr_pkg::*;

   logic [BYTE_W-1:0]    store_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] valid_ff;
   logic [MEM_DEPTH-1:0] valid_in;
   logic [BYTE_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;

   // Entries never written read as zero.
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.we) begin
         valid_in[mem_req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= store_ff[mem_req.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (mem_req.re) begin
            rd_valid_ff <= valid_ff[mem_req.raddr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// File: design/tgfr_ctrl.sv
// Frame parser, group validity timers and config registers; issues store accesses.
`default_nettype none
module tgfr_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [tgfr_pkg::CMD_W-1:0]      cmd,
   input  logic [tgfr_pkg::BYTE_W-1:0]     rx_byte,
   input  logic [tgfr_pkg::GROUP_W-1:0]    group_index,
   input  logic                            read_table,
   input  logic [tgfr_pkg::STORE_AW-1:0]   read_index,
   input  logic                            csr_we,
   input  logic [tgfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgfr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output tgfr_pkg::mem_req_type           mem_req,
   output tgfr_pkg::stage_type             stage
);
   import tgfr_pkg::*;

   logic                   awaiting_ff, awaiting_in;
   logic [BYTE_W-1:0]      byte_position_ff, byte_position_in;
   logic [BYTE_W-1:0]      frame_length_ff, frame_length_in;
   logic [BYTE_W-1:0]      frame_type_ff, frame_type_in;
   logic [BYTE_W-1:0]      data_limit_ff, data_limit_in;
   logic [TIMER_W-1:0]     timer_ff [GROUP_COUNT];
   logic [TIMER_W-1:0]     timer_in [GROUP_COUNT];
   logic [GROUP_COUNT-1:0] running_ff, running_in;
   logic [GROUP_COUNT-1:0] invalid_ff, invalid_in;
   logic [TIMER_W-1:0]     timeout_ff, timeout_in;
   logic                   second_ff, second_in;
   stage_type              stage_ff, stage_in;

   group_sel_type          rx_sel;
   group_sel_type          ft_sel;
   logic [BYTE_W-1:0]      pos_next;
   logic [BYTE_W:0]        store_idx;
   logic [BYTE_W:0]        slot_base;
   logic [GROUP_COUNT-1:0] arm_mask;

   assign rx_sel   = group_of_type(rx_byte);
   assign ft_sel   = group_of_type(frame_type_ff);
   assign pos_next = byte_position_ff + 8'd1;

   // Second group of a kind lands in the upper half of its store.
   always_comb begin
      slot_base = '0;
      if (ft_sel.group[0]) begin
         slot_base = ft_sel.group[1] ? (BYTE_W+1)'(MEASURE_GROUP_SIZE)
                                     : (BYTE_W+1)'(STATUS_GROUP_SIZE);
      end
   end
   assign store_idx = {1'b0, byte_position_ff - HEADER_BYTES} + slot_base;

   always_comb begin
      arm_mask = '0;
      arm_mask[group_index] = 1'b1;
      if (group_index == '0 && second_ff) begin
         arm_mask[1] = 1'b1;
      end
   end

   always_comb begin
      awaiting_in      = awaiting_ff;
      byte_position_in = byte_position_ff;
      frame_length_in  = frame_length_ff;
      frame_type_in    = frame_type_ff;
      data_limit_in    = data_limit_ff;
      timer_in         = timer_ff;
      running_in       = running_ff;
      invalid_in       = invalid_ff;
      timeout_in       = timeout_ff;
      second_in        = second_ff;
      mem_req          = '0;
      stage_in         = '0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TIMEOUT: timeout_in = csr_wdata[TIMER_W-1:0];
            CSR_SECOND:  second_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (accept) begin
         case (cmd_type'(cmd))
            CMD_BYTE: begin
               if (awaiting_ff) begin
                  frame_length_in  = rx_byte;
                  byte_position_in = '0;
                  if (rx_byte == '0) begin
                     stage_in.frame_done = 1'b1;   // empty frame
                  end else begin
                     awaiting_in = 1'b0;
                  end
               end else begin
                  if (byte_position_ff == TYPE_POSITION) begin
                     frame_type_in = rx_byte;
                     if (rx_sel.hit) begin
                        invalid_in[rx_sel.group] = 1'b0;
                        running_in[rx_sel.group] = 1'b0;
                        timer_in[rx_sel.group]   = '0;
                        data_limit_in = rx_sel.group[1] ? MEASURE_LIMIT : STATUS_LIMIT;
                     end
                  end else if (byte_position_ff > TYPE_POSITION &&
                               byte_position_ff < data_limit_ff &&
                               ft_sel.hit && store_idx < (BYTE_W+1)'(STORE_DEPTH)) begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = {ft_sel.group[1], store_idx[STORE_AW-1:0]};
                     mem_req.wdata = rx_byte;
                  end
                  byte_position_in = pos_next;
                  if (pos_next == frame_length_ff) begin
                     awaiting_in         = 1'b1;
                     stage_in.frame_done = 1'b1;
                  end
               end
            end
            CMD_TICK: begin
               for (int g = 0; g < GROUP_COUNT; g++) begin
                  if (running_ff[g]) begin
                     if (timer_ff[g] <= TIMER_W'(1)) begin
                        timer_in[g]   = '0;
                        running_in[g] = 1'b0;
                        invalid_in[g] = 1'b1;
                     end else begin
                        timer_in[g] = timer_ff[g] - TIMER_W'(1);
                     end
                  end
               end
            end
            CMD_POLL: begin
               for (int g = 0; g < GROUP_COUNT; g++) begin
                  if (arm_mask[g] && !running_ff[g]) begin
                     timer_in[g]   = timeout_ff;
                     running_in[g] = 1'b1;
                  end
               end
            end
            CMD_CLEAR: begin
               for (int g = 0; g < GROUP_COUNT; g++) begin
                  timer_in[g] = '0;
               end
               running_in = '0;
               invalid_in = '0;
            end
            CMD_READ: begin
               mem_req.re       = 1'b1;
               mem_req.raddr    = {read_table, read_index};
               stage_in.is_read = 1'b1;
            end
            default: begin
            end
         endcase
         stage_in.valid          = 1'b1;
         stage_in.invalid_flags  = invalid_in;
         stage_in.timers_running = running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff      <= 1'b1;
         byte_position_ff <= '0;
         frame_length_ff  <= '0;
         frame_type_ff    <= '0;
         data_limit_ff    <= '0;
         for (int g = 0; g < GROUP_COUNT; g++) begin
            timer_ff[g] <= '0;
         end
         running_ff <= '0;
         invalid_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
         second_ff  <= SECOND_RESET;
         stage_ff   <= '0;
      end else begin
         awaiting_ff      <= awaiting_in;
         byte_position_ff <= byte_position_in;
         frame_length_ff  <= frame_length_in;
         frame_type_ff    <= frame_type_in;
         data_limit_ff    <= data_limit_in;
         timer_ff         <= timer_in;
         running_ff       <= running_in;
         invalid_ff       <= invalid_in;
         timeout_ff       <= timeout_in;
         second_ff        <= second_in;
         stage_ff         <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule
`default_nettype wire

// File: design/tgfr_outq.sv
// Three-entry result queue between the store read stage and the output channel.
`default_nettype none
module tgfr_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  tgfr_pkg::result_type          push_data,
   input  logic                          pop_ready,
   output logic                          out_valid,
   output tgfr_pkg::result_type          out_data,
   output logic [tgfr_pkg::QCNT_W-1:0]   count
);
   import tgfr_pkg::*;

   result_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff, head_in;
   logic [QPTR_W-1:0]  tail_ff, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[head_ff];
   assign pop       = out_valid && pop_ready;
   assign count     = count_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QPTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: design/telemetry_group_frame_receiver_top.sv
// Result path: an accepted item is registered in the control stage and store read, then in the result queue.
// Throughput: 1 item per cycle while ready is high; all state updates and the single store
//   access happen in the accept cycle; the 3-entry queue keeps input open in short stalls.
// Reset: synchronous, active high; clears parser, timers, flags, queue and store valid
//   bits at once (store reads as zero afterwards); config returns to 1000 ticks, two groups.
`default_nettype none
module telemetry_group_frame_receiver_top (
   input  logic                             clock,
   input  logic                             reset,
   tgfr_req_if.sink                         req_chan,
   tgfr_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [tgfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tgfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tgfr_pkg::*;

   // Control path: decodes the item, updates parser and timer state, and
   // issues at most one store access (write for a data byte, read for cmd read).
   logic              accept;
   mem_req_type       mem_req;
   stage_type         stage;
   logic [BYTE_W-1:0] rd_data;

   // Output side
   result_type        push_data;
   result_type        q_data;
   logic              q_valid;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]   occupancy;

   // Items in the read stage plus items queued; the read stage always drains
   // into the queue, so accepting below queue depth can never overflow it.
   assign occupancy      = {1'b0, q_count} + (QCNT_W+1)'(stage.valid);
   assign req_chan.ready = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept         = req_chan.valid && req_chan.ready;

   tgfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_chan.cmd),
      .rx_byte     (req_chan.rx_byte),
      .group_index (req_chan.group_index),
      .read_table  (req_chan.read_table),
      .read_index  (req_chan.read_index),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mem_req     (mem_req),
      .stage       (stage)
   );

   // Each item makes its store access at its accept edge; a read always sees
   // every earlier write, so no forwarding is required.
   tgfr_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Read data only shows on read items; everything else reports zero.
   always_comb begin
      push_data.frame_done     = stage.frame_done;
      push_data.read_value     = stage.is_read ? rd_data : '0;
      push_data.invalid_flags  = stage.invalid_flags;
      push_data.timers_running = stage.timers_running;
   end

   tgfr_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (stage.valid),
      .push_data (push_data),
      .pop_ready (rsp_chan.ready),
      .out_valid (q_valid),
      .out_data  (q_data),
      .count     (q_count)
   );

   assign rsp_chan.valid          = q_valid;
   assign rsp_chan.frame_done     = q_data.frame_done;
   assign rsp_chan.read_value     = q_data.read_value;
   assign rsp_chan.invalid_flags  = q_data.invalid_flags;
   assign rsp_chan.timers_running = q_data.timers_running;

endmodule
`default_nettype wire

// File: design/tgfr_checker.sv
// Port-level checks of the telemetry group frame receiver and their bind.
`default_nettype none
`include "telemetry_group_frame_receiver_top_defines.svh"
module tgfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_frame_done,
   input logic [7:0] rsp_read_value,
   input logic [3:0] rsp_invalid_flags,
   input logic [3:0] rsp_timers_running
);

   `TGFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_done) && $stable(rsp_read_value) && $stable(rsp_invalid_flags) && $stable(rsp_timers_running), "stalled result changed")

   `TGFR_ASSERT_NEXT_NORST(a_reset_empty, clock, reset, !rsp_valid, "result valid right after reset")

   `TGFR_ASSERT_IMPL(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result appeared without an accepted item")

   `TGFR_ASSERT_IMPL(a_done_no_read, clock, reset, rsp_valid && rsp_frame_done, rsp_read_value == 8'd0, "frame end carries read data")

endmodule

bind telemetry_group_frame_receiver_top tgfr_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_frame_done     (rsp_chan.frame_done),
   .rsp_read_value     (rsp_chan.read_value),
   .rsp_invalid_flags  (rsp_chan.invalid_flags),
   .rsp_timers_running (rsp_chan.timers_running)
);
`default_nettype wire
